>>> rtl/tamf_pkg.sv
package tamf_pkg;

	localparam int TRIG_STAGES_DEF = 16;
	localparam int TRIG_STAGES_MAX = 24;
	localparam int DRIVE_LIMIT     = 65535;

	// register indexes on the configuration port
	localparam logic [7:0] REG_REV_SPEED_GAIN   = 8'd0;
	localparam logic [7:0] REG_REV_TORQUE_GAIN  = 8'd1;
	localparam logic [7:0] REG_LOAD_WEIGHT      = 8'd2;
	localparam logic [7:0] REG_RAIL_MOMENT      = 8'd3;
	localparam logic [7:0] REG_ARM_OFFSET       = 8'd4;
	localparam logic [7:0] REG_SLIDE_SPEED_GAIN = 8'd5;
	localparam logic [7:0] REG_SLIDE_FORCE_GAIN = 8'd6;
	localparam logic [7:0] REG_LOAD_MASS        = 8'd7;

	// cordic start vector, 1/K in Q1.30
	localparam logic signed [33:0] CORDIC_X0 = 34'sh026DD3B6A;

	// atan(2^-i) in 2^32 units per turn
	localparam logic [31:0] ATAN_TURNS [TRIG_STAGES_MAX] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// fraction bits of each drive term: arm speed, torque, slide speed, force
	localparam int DRIVE_FRAC [4] = '{10, 16, 15, 16};

	// shift right by s, rounding half away from zero
	function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
			input int unsigned s);
		logic [63:0] m;
		begin
			m = v[63] ? 64'(-v) : 64'(v);
			m = (m + (64'd1 << (s - 1))) >> s;
			return v[63] ? -$signed(m) : $signed(m);
		end
	endfunction

endpackage

>>> rtl/two_axis_motor_feedforward.sv
// channel  | dir | width | content
// s_*      | in  | 64    | item transfer: arm angle, arm speed, slide position, slide speed
// m_*      | out | 72    | result transfer: four saturated drive values
// cfg_*    | in  | 8+32  | register write transfer, always ready
//
// one item enters per cycle while the output is not stalled
// the pipe is the cordic chain, one rotation per stage, plus eight
// stages of input capture, multiply and rounding
// arst_n clears every valid bit and the configuration registers to zero; the data path is not reset
// a stall on m_tready freezes the whole pipe; s_tready drops only while the
// output stage holds a result that has not been taken
module two_axis_motor_feedforward #(
	parameter int TRIG_STAGES = tamf_pkg::TRIG_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// arm_angle[15:0], arm_speed[31:16], slide_position[47:32], slide_speed[63:48]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// rev_speed_drive[16:0], rev_load_drive[33:17], slide_speed_drive[50:34],
	// slide_load_drive[67:51], zero fill above
	output logic [71:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int T = TRIG_STAGES;

	// configuration registers
	logic [31:0]        rev_speed_gain_q, rev_torque_gain_q, load_weight_q, rail_moment_q;
	logic [31:0]        slide_speed_gain_q, slide_force_gain_q, load_mass_q;
	logic signed [15:0] arm_offset_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_speed_gain_q   <= '0;
			rev_torque_gain_q  <= '0;
			load_weight_q      <= '0;
			rail_moment_q      <= '0;
			arm_offset_q       <= '0;
			slide_speed_gain_q <= '0;
			slide_force_gain_q <= '0;
			load_mass_q        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tamf_pkg::REG_REV_SPEED_GAIN:   rev_speed_gain_q   <= cfg_data;
				tamf_pkg::REG_REV_TORQUE_GAIN:  rev_torque_gain_q  <= cfg_data;
				tamf_pkg::REG_LOAD_WEIGHT:      load_weight_q      <= cfg_data;
				tamf_pkg::REG_RAIL_MOMENT:      rail_moment_q      <= cfg_data;
				tamf_pkg::REG_ARM_OFFSET:       arm_offset_q       <= cfg_data[15:0];
				tamf_pkg::REG_SLIDE_SPEED_GAIN: slide_speed_gain_q <= cfg_data;
				tamf_pkg::REG_SLIDE_FORCE_GAIN: slide_force_gain_q <= cfg_data;
				tamf_pkg::REG_LOAD_MASS:        load_mass_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// global stall: whole pipe advances when the output slot is free or taken
	logic en;
	logic v_s7;
	assign en       = !v_s7 || m_tready;
	assign s_tready = en;

	// cordic chain, stage 0 is the input capture
	logic               cv_s [0:T];
	logic signed [33:0] cx_s [0:T];
	logic signed [33:0] cy_s [0:T];
	logic signed [33:0] cz_s [0:T];
	logic               flip_s [0:T];
	logic signed [15:0] w_s [0:T];
	logic signed [15:0] pos_s [0:T];
	logic signed [15:0] sd_s [0:T];

	logic [15:0] ang_in;
	logic        flip_in;
	assign ang_in  = s_tdata[15:0];
	// second and third quadrant are rotated by half a turn
	assign flip_in = ang_in[15] ^ ang_in[14];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cv_s[0] <= 1'b0;
		else if (en) cv_s[0] <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0]   <= tamf_pkg::CORDIC_X0;
			cy_s[0]   <= '0;
			cz_s[0]   <= {{2{ang_in[15] ^ flip_in}}, ang_in[15] ^ flip_in, ang_in[14:0],
				16'h0000};
			flip_s[0] <= flip_in;
			w_s[0]    <= s_tdata[31:16];
			pos_s[0]  <= s_tdata[47:32];
			sd_s[0]   <= s_tdata[63:48];
		end
	end

	for (genvar k = 0; k < T; k++) begin : g_cordic
		logic signed [33:0] atn;
		assign atn = $signed({2'b00, tamf_pkg::ATAN_TURNS[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cv_s[k+1] <= 1'b0;
			else if (en) cv_s[k+1] <= cv_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!cz_s[k][33]) begin
					cx_s[k+1] <= cx_s[k] - (cy_s[k] >>> k);
					cy_s[k+1] <= cy_s[k] + (cx_s[k] >>> k);
					cz_s[k+1] <= cz_s[k] - atn;
				end else begin
					cx_s[k+1] <= cx_s[k] + (cy_s[k] >>> k);
					cy_s[k+1] <= cy_s[k] - (cx_s[k] >>> k);
					cz_s[k+1] <= cz_s[k] + atn;
				end
				flip_s[k+1] <= flip_s[k];
				w_s[k+1]    <= w_s[k];
				pos_s[k+1]  <= pos_s[k];
				sd_s[k+1]   <= sd_s[k];
			end
		end
	end

	// stage 1: undo the half turn, round sin and cos to Q16, pos + offset, speed squared
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [17:0] s16_s1, c16_s1;
	logic signed [16:0] ps_s1;
	logic [31:0]        w2_s1;
	logic signed [15:0] w_s1, pos_s1, sd_s1;
	logic signed [33:0] xf, yf;
	logic signed [31:0] wsq;

	assign xf  = flip_s[T] ? -cx_s[T] : cx_s[T];
	assign yf  = flip_s[T] ? -cy_s[T] : cy_s[T];
	assign wsq = w_s[T] * w_s[T];

	always_ff @(posedge clk) begin
		if (en) begin
			s16_s1 <= 18'(tamf_pkg::rnd_sh(64'(yf), 14));
			c16_s1 <= 18'(tamf_pkg::rnd_sh(64'(xf), 14));
			ps_s1  <= 17'(pos_s[T]) + 17'(arm_offset_q);
			w2_s1  <= $unsigned(wsq);
			w_s1   <= w_s[T];
			pos_s1 <= pos_s[T];
			sd_s1  <= sd_s[T];
		end
	end

	// stage 2: moment about the joint, speed squared times position, weight times cos
	logic signed [50:0] m31_s2, lwc_s2;
	logic signed [47:0] w2p_s2;
	logic signed [17:0] s16_s2;
	logic signed [15:0] w_s2, sd_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			m31_s2 <= 51'($signed({1'b0, load_weight_q}) * ps_s1)
				- 51'($signed({4'b0000, rail_moment_q, 15'h0000}));
			w2p_s2 <= 48'($signed({1'b0, w2_s1}) * pos_s1);
			lwc_s2 <= 51'($signed({1'b0, load_weight_q}) * c16_s1);
			s16_s2 <= s16_s1;
			w_s2   <= w_s1;
			sd_s2  <= sd_s1;
		end
	end

	// stage 3: round moment to Q16 and centrifugal factor to Q16
	logic signed [36:0] m16_s3;
	logic signed [29:0] w2s_s3;
	logic signed [50:0] lwc_s3;
	logic signed [17:0] s16_s3;
	logic signed [15:0] w_s3, sd_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			m16_s3 <= 37'(tamf_pkg::rnd_sh(64'(m31_s2), 15));
			w2s_s3 <= 30'(tamf_pkg::rnd_sh(64'(w2p_s2), 19));
			lwc_s3 <= lwc_s2;
			s16_s3 <= s16_s2;
			w_s3   <= w_s2;
			sd_s3  <= sd_s2;
		end
	end

	// stage 4: moment times sin, mass times centrifugal factor
	logic signed [54:0] tqp_s4;
	logic signed [62:0] lmw_s4;
	logic signed [50:0] lwc_s4;
	logic signed [15:0] w_s4, sd_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			tqp_s4 <= 55'(m16_s3 * s16_s3);
			lmw_s4 <= 63'($signed({1'b0, load_mass_q}) * w2s_s3);
			lwc_s4 <= lwc_s3;
			w_s4   <= w_s3;
			sd_s4  <= sd_s3;
		end
	end

	// stage 5: torque and force rounded to Q16
	logic signed [38:0] torque_s5;
	logic signed [47:0] force_s5;
	logic signed [15:0] w_s5, sd_s5;
	logic signed [63:0] fsum;

	assign fsum = 64'(lwc_s4) + 64'(lmw_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			torque_s5 <= 39'(tamf_pkg::rnd_sh(64'(tqp_s4), 16));
			force_s5  <= 48'(tamf_pkg::rnd_sh(fsum, 16));
			w_s5      <= w_s4;
			sd_s5     <= sd_s4;
		end
	end

	// stage 6: magnitude times integer and fraction halves of each gain
	logic signed [47:0] trm [4];
	logic [31:0]        gain [4];
	logic [63:0]        ph_s6 [4];
	logic [63:0]        pl_s6 [4];
	logic [3:0]         neg_s6;
	logic [47:0]        mag [4];

	always_comb begin
		trm[0]  = 48'(w_s5);
		trm[1]  = 48'(torque_s5);
		trm[2]  = 48'(sd_s5);
		trm[3]  = force_s5;
		gain[0] = rev_speed_gain_q;
		gain[1] = rev_torque_gain_q;
		gain[2] = slide_speed_gain_q;
		gain[3] = slide_force_gain_q;
		for (int i = 0; i < 4; i++) begin
			mag[i] = trm[i][47] ? $unsigned(-trm[i]) : $unsigned(trm[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				ph_s6[i]  <= 64'(mag[i] * gain[i][31:16]);
				pl_s6[i]  <= 64'(mag[i] * gain[i][15:0]);
				neg_s6[i] <= trm[i][47];
			end
		end
	end

	// stage 7: sum, round away from zero, saturate, restore sign; output register
	logic [63:0]        psum [4];
	logic [63:0]        prnd [4];
	logic [16:0]        psat [4];
	logic signed [16:0] drv_s7 [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			psum[i] = ph_s6[i] + (pl_s6[i] >> 16);
			prnd[i] = (psum[i] + (64'd1 << (tamf_pkg::DRIVE_FRAC[i] - 1)))
				>> tamf_pkg::DRIVE_FRAC[i];
			psat[i] = (prnd[i] > 64'(tamf_pkg::DRIVE_LIMIT)) ?
				17'(tamf_pkg::DRIVE_LIMIT) : prnd[i][16:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				drv_s7[i] <= neg_s6[i] ? -$signed(psat[i]) : $signed(psat[i]);
			end
		end
	end

	// valid bits of the post-cordic stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= cv_s[T];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	assign m_tvalid = v_s7;
	assign m_tdata  = {4'b0000, drv_s7[3], drv_s7[2], drv_s7[1], drv_s7[0]};

	// stall only when a finished result is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without a blocked result");

	// saturation keeps every drive within the limit; checked here on the two load drives
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (drv_s7[1] <= 17'sd65535 && drv_s7[1] >= -17'sd65535
			&& drv_s7[3] <= 17'sd65535 && drv_s7[3] >= -17'sd65535))
		else $error("drive value beyond limit");

	// a zero speed gain gives zero speed drives
	a_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && rev_speed_gain_q == 32'd0 && slide_speed_gain_q == 32'd0)
		|-> (drv_s7[0] == 17'sd0 && drv_s7[2] == 17'sd0))
		else $error("nonzero speed drive with zero gain");

	// a blocked result moves the pipe not at all
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result lost while blocked");

endmodule

>>> tb/sv/two_axis_motor_feedforward_tb.sv
`timescale 1ns / 1ps

module two_axis_motor_feedforward_tb;

	localparam int STAGES  = 16;
	localparam int LATENCY = STAGES + 8;

	typedef struct packed {
		logic [16:0] rev_speed;
		logic [16:0] rev_load;
		logic [16:0] slide_speed;
		logic [16:0] slide_load;
	} drives_t;

	typedef struct {
		logic [15:0] angle;
		logic [15:0] speed;
		logic [15:0] pos;
		logic [15:0] sspeed;
		logic [3:0]  typed;  // rev_speed, rev_load, slide_speed, slide_load from bit 0 up
		drives_t     want;
	} row_t;

	// atan(2^-i) in 2^32 units per turn
	localparam longint ATAN [STAGES] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// arm_angle, arm_speed, slide_position, slide_speed from bit 0 up
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// rev_speed_drive, rev_load_drive, slide_speed_drive, slide_load_drive from bit 0 up
	logic [71:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [31:0] cfg_data;

	// predictor copy of the register file
	logic [31:0] g_rev_speed, g_rev_torque, g_weight, g_rail;
	logic [31:0] g_slide_speed, g_slide_force, g_mass;
	longint      g_offset;

	drives_t pending_drives[$];
	int      fails;
	bit      calm;  // no gaps on either side while set

	two_axis_motor_feedforward dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous ceiling, far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// shift right, rounding half away from zero
	function automatic longint round_shift(input longint v, input int s);
		longint unsigned m;
		begin
			m = (v < 0) ? longint'(-v) : longint'(v);
			m = (m + (64'd1 << (s - 1))) >> s;
			return (v < 0) ? -longint'(m) : longint'(m);
		end
	endfunction

	// rotation-mode cordic, sine and cosine in Q16
	function automatic void sin_cos(input logic [15:0] angle, output longint s16,
			output longint c16);
		logic [31:0] z32;
		longint x, y, z, nx;
		bit flip;
		begin
			z32 = {angle, 16'h0000};
			flip = (angle >= 16'h4000) && (angle < 16'hC000);
			if (flip) z32 = z32 - 32'h80000000;
			z = longint'($signed(z32));
			x = 64'h26DD3B6A;
			y = 0;
			for (int i = 0; i < STAGES; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y  = y + (x >>> i);
					z  = z - ATAN[i];
				end else begin
					nx = x + (y >>> i);
					y  = y - (x >>> i);
					z  = z + ATAN[i];
				end
				x = nx;
			end
			if (flip) begin
				x = -x;
				y = -y;
			end
			s16 = round_shift(y, 14);
			c16 = round_shift(x, 14);
		end
	endfunction

	// term times Q16.16 gain, rounded by the term's fraction bits, saturated
	function automatic logic [16:0] to_counts(input longint v, input logic [31:0] g,
			input int f);
		longint unsigned u, p;
		longint r;
		begin
			u = (v < 0) ? longint'(-v) : longint'(v);
			p = u * longint'(g[31:16]) + ((u * longint'(g[15:0])) >> 16);
			p = (p + (64'd1 << (f - 1))) >> f;
			if (p > 64'(tamf_pkg::DRIVE_LIMIT)) p = 64'(tamf_pkg::DRIVE_LIMIT);
			r = (v < 0) ? -longint'(p) : longint'(p);
			return r[16:0];
		end
	endfunction

	function automatic drives_t feedforward(input logic [15:0] angle, input logic [15:0] speed,
			input logic [15:0] pos_in, input logic [15:0] sspeed);
		longint w, pos, sd, s16, c16, moment, torque, w2p, frc;
		drives_t d;
		begin
			w   = longint'($signed(speed));
			pos = longint'($signed(pos_in));
			sd  = longint'($signed(sspeed));
			sin_cos(angle, s16, c16);
			moment = round_shift(longint'(g_weight) * (pos + g_offset)
				- (longint'(g_rail) << 15), 15);
			torque = round_shift(moment * s16, 16);
			w2p    = round_shift(w * w * pos, 19);
			frc    = round_shift(longint'(g_weight) * c16 + longint'(g_mass) * w2p, 16);
			d.rev_speed   = to_counts(w, g_rev_speed, 10);
			d.rev_load    = to_counts(torque, g_rev_torque, 16);
			d.slide_speed = to_counts(sd, g_slide_speed, 15);
			d.slide_load  = to_counts(frc, g_slide_force, 16);
			return d;
		end
	endfunction

	// one register write transfer, mirrored into the predictor
	task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			tamf_pkg::REG_REV_SPEED_GAIN:   g_rev_speed   = val;
			tamf_pkg::REG_REV_TORQUE_GAIN:  g_rev_torque  = val;
			tamf_pkg::REG_LOAD_WEIGHT:      g_weight      = val;
			tamf_pkg::REG_RAIL_MOMENT:      g_rail        = val;
			tamf_pkg::REG_ARM_OFFSET:       g_offset      = longint'($signed(val[15:0]));
			tamf_pkg::REG_SLIDE_SPEED_GAIN: g_slide_speed = val;
			tamf_pkg::REG_SLIDE_FORCE_GAIN: g_slide_force = val;
			tamf_pkg::REG_LOAD_MASS:        g_mass        = val;
			default: ;  // out of range index, write dropped
		endcase
	endtask

	// mode 0 random scale, 1 all at maximum but the offset at its most negative, 2 all zero
	task automatic load_gains(input int mode);
		logic [31:0] v [8];
		for (int i = 0; i < 8; i++) begin
			case (mode)
				1: v[i] = 32'hFFFF_FFFF;
				2: v[i] = 32'h0;
				default: v[i] = $urandom >> $urandom_range(0, 24);
			endcase
		end
		if (mode == 0) v[tamf_pkg::REG_ARM_OFFSET] = $urandom;
		else if (mode == 1) v[tamf_pkg::REG_ARM_OFFSET] = 32'h0000_8000;  // most negative offset
		write_reg(tamf_pkg::REG_REV_SPEED_GAIN,   v[0]);
		write_reg(tamf_pkg::REG_REV_TORQUE_GAIN,  v[1]);
		write_reg(tamf_pkg::REG_LOAD_WEIGHT,      v[2]);
		write_reg(tamf_pkg::REG_RAIL_MOMENT,      v[3]);
		write_reg(tamf_pkg::REG_ARM_OFFSET,       v[4]);
		write_reg(tamf_pkg::REG_SLIDE_SPEED_GAIN, v[5]);
		write_reg(tamf_pkg::REG_SLIDE_FORCE_GAIN, v[6]);
		write_reg(tamf_pkg::REG_LOAD_MASS,        v[7]);
	endtask

	// one item transfer; returns at the edge that took it
	task automatic send_item(input logic [15:0] angle, input logic [15:0] speed,
			input logic [15:0] pos, input logic [15:0] sspeed, input logic [3:0] typed,
			input drives_t want);
		int gap;
		drives_t d;
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {sspeed, pos, speed, angle};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		d = feedforward(angle, speed, pos, sspeed);
		// hand-read values override the predictor where given
		if (typed[0]) d.rev_speed   = want.rev_speed;
		if (typed[1]) d.rev_load    = want.rev_load;
		if (typed[2]) d.slide_speed = want.slide_speed;
		if (typed[3]) d.slide_load  = want.slide_load;
		pending_drives.push_back(d);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_drives.size() != 0) @(posedge clk);
	endtask

	// receiver side: random stalls, with calm stretches
	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = calm ? 0 : $urandom_range(0, 10);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// result checker, oldest expectation first
	always @(posedge clk) begin
		drives_t got, exp_d;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[16:0], m_tdata[33:17], m_tdata[50:34], m_tdata[67:51]};
			if (pending_drives.size() == 0) begin
				$error("result transfer with nothing expected: %h", m_tdata);
				fails++;
			end else begin
				exp_d = pending_drives.pop_front();
				if (got.rev_speed !== exp_d.rev_speed) begin
					$error("rev_speed_drive expected %h got %h", exp_d.rev_speed, got.rev_speed);
					fails++;
				end
				if (got.rev_load !== exp_d.rev_load) begin
					$error("rev_load_drive expected %h got %h", exp_d.rev_load, got.rev_load);
					fails++;
				end
				if (got.slide_speed !== exp_d.slide_speed) begin
					$error("slide_speed_drive expected %h got %h",
						exp_d.slide_speed, got.slide_speed);
					fails++;
				end
				if (got.slide_load !== exp_d.slide_load) begin
					$error("slide_load_drive expected %h got %h",
						exp_d.slide_load, got.slide_load);
					fails++;
				end
			end
		end
	end

	initial begin
		row_t zero_rows [6];
		row_t max_rows [12];
		drives_t none;
		logic [15:0] sp, ps;
		int mode;

		none = '0;
		fails = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		g_rev_speed = 0; g_rev_torque = 0; g_weight = 0; g_rail = 0;
		g_offset = 0; g_slide_speed = 0; g_slide_force = 0; g_mass = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers straight out of reset are zero, so every drive is zero
		zero_rows = '{
			'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'hF, '0},
			'{16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4'hF, '0},
			'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'hF, '0},
			'{16'h4000, 16'h7FFF, 16'h8000, 16'h7FFF, 4'hF, '0},
			'{16'hC000, 16'h8000, 16'h7FFF, 16'h8000, 4'hF, '0},
			'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 4'hF, '0}
		};
		foreach (zero_rows[i])
			send_item(zero_rows[i].angle, zero_rows[i].speed, zero_rows[i].pos,
				zero_rows[i].sspeed, zero_rows[i].typed, zero_rows[i].want);
		drain();

		// registers at top, offset most negative; then writes past the end must not land
		load_gains(1);
		write_reg(8'd8, 32'h0);
		write_reg(8'd255, 32'h0);

		// full-scale arm and slide speeds saturate the speed drives; zero speeds give zero
		max_rows = '{
			'{16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 4'h5, '{17'h0FFFF, 17'h0, 17'h0, 17'h0}},
			'{16'h0000, 16'h8000, 16'h0000, 16'h8000, 4'h5,
				'{17'h10001, 17'h0, 17'h10001, 17'h0}},
			'{16'h4000, 16'h0000, 16'h7FFF, 16'h0000, 4'h5, '0},
			'{16'h3FFF, 16'h0000, 16'h8000, 16'h0000, 4'h5, '0},
			'{16'hBFFF, 16'h0001, 16'h0001, 16'h0001, 4'h0, '0},
			'{16'hC000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'h0, '0},
			'{16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4'h0, '0},
			'{16'h2000, 16'h8000, 16'h7FFF, 16'h0000, 4'h0, '0},
			'{16'hE000, 16'h0400, 16'h4000, 16'h4000, 4'h0, '0},
			'{16'h7FFF, 16'h0001, 16'h0000, 16'h0000, 4'h0, '0},
			'{16'h8001, 16'h7FFF, 16'h8000, 16'h7FFF, 4'h0, '0},
			'{16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 4'h0, '0}
		};
		foreach (max_rows[i])
			send_item(max_rows[i].angle, max_rows[i].speed, max_rows[i].pos,
				max_rows[i].sspeed, max_rows[i].typed, max_rows[i].want);
		drain();

		// random phases, each under its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			mode = (ph == 2) ? 1 : (ph == 4) ? 2 : 0;
			load_gains(mode);
			if (ph == 3) write_reg(tamf_pkg::REG_ARM_OFFSET, 32'h0000_7FFF);
			calm = (ph == 1);
			for (int k = 0; k < 150; k++) begin
				sp = 16'($urandom);
				ps = 16'($urandom);
				// a quarter at modest speeds and positions where the drives rarely clip
				if ($urandom_range(0, 3) == 0) begin
					sp = 16'($signed(sp) >>> $urandom_range(4, 12));
					ps = 16'($signed(ps) >>> $urandom_range(2, 10));
				end
				send_item(16'($urandom), sp, ps, 16'($urandom), 4'h0, none);
			end
			drain();
		end

		repeat (LATENCY + 20) @(posedge clk);
		if (fails == 0 && pending_drives.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
